@@ design/rdq_pkg.sv @@
package rdq_pkg;

	localparam int DATA_W = 32;
	localparam int DEPTH_DEF = 16;

	typedef enum logic [2:0] {
		FN_PUSH_BACK  = 3'd0,
		FN_PUSH_FRONT = 3'd1,
		FN_POP_BACK   = 3'd2,
		FN_POP_FRONT  = 3'd3,
		FN_REVERSE    = 3'd4,
		FN_QUERY      = 3'd5
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

endpackage

@@ design/reversible_deque.sv @@
// Double-ended queue of signed 32-bit values in a ring of DEPTH entries, with
// a reverse flag that swaps the logical front and back in one step. A command
// is taken on every clock edge where start is high; busy is always low, so one
// command per cycle is sustained. Its result (logical front and back values,
// -1 when empty, the count and a status) appears in the next cycle for exactly
// one cycle with done high, taken from the registered read of the entry memory,
// which has one write port and two read ports, one per end.
// The receiver cannot stall and must take each result beat as it comes.
// Pops on an empty queue and pushes on a full one leave the queue untouched
// and are reported in status.
module reversible_deque
	import rdq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [2:0]               func,
	input  logic signed [DATA_W-1:0] value,
	output logic                     done,
	output logic signed [DATA_W-1:0] front_value,
	output logic signed [DATA_W-1:0] back_value,
	output logic [CNT_W-1:0]         count,
	output logic [1:0]               status
);

	function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
		return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
	endfunction

	logic [IDX_W-1:0] head_q, tail_q, head_d, tail_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             rev_q, rev_d;
	logic             done_q;
	status_t          st_d, st_s1;

	logic                     we;
	logic [IDX_W-1:0]         waddr, ra_head, ra_tail;
	logic signed [DATA_W-1:0] entries_q [DEPTH];
	logic signed [DATA_W-1:0] head_rd_s1, tail_rd_s1;

	logic accept;
	logic at_tail;

	assign busy = 1'b0;
	assign accept = start;

	always_comb begin
		head_d = head_q;
		tail_d = tail_q;
		cnt_d = cnt_q;
		rev_d = rev_q;
		st_d = ST_OK;
		we = 1'b0;
		waddr = tail_q;
		at_tail = 1'b0;
		if (accept) begin
			case (func)
				FN_PUSH_BACK, FN_PUSH_FRONT: begin
					if (cnt_q == CNT_W'(DEPTH)) begin
						st_d = ST_FULL;
					end else begin
						// logical back sits at the physical tail unless reversed
						at_tail = (func == FN_PUSH_BACK) ^ rev_q;
						we = 1'b1;
						cnt_d = cnt_q + 1'b1;
						if (at_tail) begin
							waddr = tail_q;
							tail_d = ring_next(tail_q);
						end else begin
							waddr = ring_prev(head_q);
							head_d = ring_prev(head_q);
						end
					end
				end
				FN_POP_BACK, FN_POP_FRONT: begin
					if (cnt_q == '0) begin
						st_d = ST_EMPTY;
					end else begin
						at_tail = (func == FN_POP_BACK) ^ rev_q;
						cnt_d = cnt_q - 1'b1;
						if (at_tail) begin
							tail_d = ring_prev(tail_q);
						end else begin
							head_d = ring_next(head_q);
						end
					end
				end
				FN_REVERSE: begin
					rev_d = ~rev_q;
				end
				default: begin
				end
			endcase
		end
		ra_head = head_d;
		ra_tail = ring_prev(tail_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q <= '0;
			rev_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			head_q <= head_d;
			tail_q <= tail_d;
			cnt_q <= cnt_d;
			rev_q <= rev_d;
			done_q <= accept;
		end
	end

	// end reads see this cycle's push through the bypass
	always_ff @(posedge clk) begin
		if (we) begin
			entries_q[waddr] <= value;
		end
		head_rd_s1 <= (we && waddr == ra_head) ? value : entries_q[ra_head];
		tail_rd_s1 <= (we && waddr == ra_tail) ? value : entries_q[ra_tail];
		st_s1 <= st_d;
	end

	// state registers already hold this beat's post-step count and flag
	assign done = done_q;
	assign count = cnt_q;
	assign status = st_s1;
	always_comb begin
		if (cnt_q == '0) begin
			front_value = -32'sd1;
			back_value = -32'sd1;
		end else if (rev_q) begin
			front_value = tail_rd_s1;
			back_value = head_rd_s1;
		end else begin
			front_value = head_rd_s1;
			back_value = tail_rd_s1;
		end
	end

	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> done)
		else $error("result beat missing after accepted command");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("count above depth");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!start |=> (cnt_q == $past(cnt_q) && head_q == $past(head_q)
			&& tail_q == $past(tail_q) && rev_q == $past(rev_q)))
		else $error("state moved without a command");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> (count == CNT_W'(DEPTH)))
		else $error("push dropped while not full");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_EMPTY) |-> (count == '0))
		else $error("pop ignored while not empty");

endmodule

@@ sim/tb_reversible_deque.sv @@
`timescale 1ns / 100ps

module tb_reversible_deque;
	import rdq_pkg::*;

	localparam int RING = DEPTH_DEF;
	localparam int CNT_W = $clog2(DEPTH_DEF + 1);
	localparam int CYCLE_LIMIT = 60000;
	localparam int TAIL_CYCLES = 4;
	localparam int RANDOM_PER_PHASE = 217;

	// codes outside func_t that the block handles as a query
	localparam logic [2:0] FN_SPARE_LO = 3'd6;
	localparam logic [2:0] FN_SPARE_HI = 3'd7;

	typedef struct {
		logic signed [DATA_W-1:0] front;
		logic signed [DATA_W-1:0] back;
		logic [CNT_W-1:0]         fill;
		status_t                  st;
	} deque_view_t;

	class deque_scoreboard;
		logic signed [DATA_W-1:0] slots [RING];
		int           head_ptr;
		int           tail_ptr;
		int           fill;
		bit           flipped;
		deque_view_t  views_due [$];
		int unsigned  errors;

		function new();
			head_ptr = 0;
			tail_ptr = 0;
			fill = 0;
			flipped = 1'b0;
			errors = 0;
		endfunction

		function int pending();
			return views_due.size();
		endfunction

		function void note_command(logic [2:0] code, logic signed [DATA_W-1:0] v);
			status_t st;
			bit at_tail;
			deque_view_t view;
			logic signed [DATA_W-1:0] phys_front;
			logic signed [DATA_W-1:0] phys_back;
			st = ST_OK;
			case (code)
				FN_PUSH_BACK, FN_PUSH_FRONT: begin
					if (fill == RING) begin
						st = ST_FULL;
					end else begin
						at_tail = (code == FN_PUSH_BACK) ^ flipped;
						if (at_tail) begin
							slots[tail_ptr] = v;
							tail_ptr = (tail_ptr + 1) % RING;
						end else begin
							head_ptr = (head_ptr + RING - 1) % RING;
							slots[head_ptr] = v;
						end
						fill++;
					end
				end
				FN_POP_BACK, FN_POP_FRONT: begin
					if (fill == 0) begin
						st = ST_EMPTY;
					end else begin
						at_tail = (code == FN_POP_BACK) ^ flipped;
						if (at_tail)
							tail_ptr = (tail_ptr + RING - 1) % RING;
						else
							head_ptr = (head_ptr + 1) % RING;
						fill--;
					end
				end
				FN_REVERSE: flipped = ~flipped;
				default: ;
			endcase
			if (fill == 0) begin
				phys_front = -1;
				phys_back = -1;
			end else begin
				phys_front = slots[head_ptr];
				phys_back = slots[(tail_ptr + RING - 1) % RING];
			end
			view.front = flipped ? phys_back : phys_front;
			view.back = flipped ? phys_front : phys_back;
			view.fill = fill[CNT_W-1:0];
			view.st = st;
			views_due = {views_due, view};
		endfunction

		function void check_result(logic signed [DATA_W-1:0] front,
				logic signed [DATA_W-1:0] back, logic [CNT_W-1:0] cnt, logic [1:0] st);
			deque_view_t want;
			if (views_due.size() == 0) begin
				$error("result beat with no command outstanding");
				errors++;
				return;
			end
			want = views_due[0];
			views_due.delete(0);
			if (front !== want.front) begin
				$error("front_value: expected %0d, got %0d", want.front, front);
				errors++;
			end
			if (back !== want.back) begin
				$error("back_value: expected %0d, got %0d", want.back, back);
				errors++;
			end
			if (cnt !== want.fill) begin
				$error("count: expected %0d, got %0d", want.fill, cnt);
				errors++;
			end
			if (st !== want.st) begin
				$error("status: expected %0d, got %0d", want.st, st);
				errors++;
			end
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic [2:0]               func = 3'd0;
	logic signed [DATA_W-1:0] value = '0;
	logic                     done;
	logic signed [DATA_W-1:0] front_value;
	logic signed [DATA_W-1:0] back_value;
	logic [CNT_W-1:0]         count;
	logic [1:0]               status;

	deque_scoreboard board = new();
	int unsigned cycles = 0;
	int idle_pct = 0;

	reversible_deque u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.value      (value),
		.done       (done),
		.front_value(front_value),
		.back_value (back_value),
		.count      (count),
		.status     (status)
	);

	always #2 clk = ~clk;

	// outputs and handshake are sampled at the edge, before this edge's updates land
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL reversible_deque");
			$finish;
		end else if (arst_n) begin
			if (done)
				board.check_result(front_value, back_value, count, status);
			if (start && !busy)
				board.note_command(func, value);
		end
	end

	// each cycle before a beat is idle with probability idle_pct
	task automatic send_command(input logic [2:0] code, input logic signed [DATA_W-1:0] v);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			func <= 3'($urandom);
			value <= $urandom;
			@(posedge clk);
		end
		start <= 1'b1;
		func <= code;
		value <= v;
		do @(posedge clk); while (busy);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(15))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return -1;
			3: return 0;
			default: return $urandom;
		endcase
	endfunction

	// fill-leaning, drain-leaning and balanced stretches walk the level across the ring
	task automatic run_random(input int items);
		int left;
		int push_pct;
		int pick;
		logic [2:0] code;
		left = 0;
		push_pct = 50;
		for (int n = 0; n < items; n++) begin
			if (left == 0) begin
				left = $urandom_range(16, 48);
				case ($urandom_range(2))
					0: push_pct = 80;
					1: push_pct = 20;
					default: push_pct = 50;
				endcase
			end
			left--;
			pick = $urandom_range(99);
			if (pick < 8)
				code = FN_REVERSE;
			else if (pick < 12)
				code = FN_QUERY;
			else if (pick < 14)
				code = $urandom_range(1) ? FN_SPARE_HI : FN_SPARE_LO;
			else if ($urandom_range(99) < push_pct)
				code = $urandom_range(1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
			else
				code = $urandom_range(1) ? FN_POP_BACK : FN_POP_FRONT;
			send_command(code, pick_value());
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_command(FN_QUERY, 0);
		send_command(FN_POP_BACK, 0);
		send_command(FN_POP_FRONT, 0);
		send_command(FN_REVERSE, 0);
		send_command(FN_PUSH_BACK, 32'sh7FFF_FFFF);
		send_command(FN_PUSH_FRONT, 32'sh8000_0000);
		send_command(FN_SPARE_LO, -1);
		send_command(FN_REVERSE, 0);
		send_command(FN_POP_FRONT, 0);
		send_command(FN_POP_BACK, 0);
		send_command(FN_SPARE_HI, -1);
		// one push past full gets dropped
		for (int i = 0; i <= RING; i++)
			send_command(i[0] ? FN_PUSH_FRONT : FN_PUSH_BACK, (i[0] ? -1 : 1) << i);
		send_command(FN_REVERSE, 0);
		send_command(FN_POP_BACK, 0);
		send_command(FN_QUERY, 0);

		// receiver cannot stall, so only the sender idles
		run_random(RANDOM_PER_PHASE);
		idle_pct = 55;
		run_random(RANDOM_PER_PHASE);
		idle_pct = 38;
		run_random(RANDOM_PER_PHASE);
		start <= 1'b0;

		while (board.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("PASS reversible_deque");
		else
			$display("FAIL reversible_deque");
		$finish;
	end

endmodule
